// ===== design/rtc3w_pkg.sv =====
// rtc3w_pkg: shared codes, constants and conversion functions for the
// three-wire serial master core; no dependencies
package rtc3w_pkg;

    localparam logic [1:0] KIND_IDLE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] READ_FLAG  = 8'h01;
    localparam logic [4:0] LAST_TICK  = 5'd31;
    localparam logic [4:0] READ_START = 5'd16;

    // decimal to bcd, tens by reciprocal multiply (exact below 1029)
    function automatic logic [7:0] to_bcd(input logic [7:0] d);
        logic [15:0] prod;
        logic [4:0]  tens;
        logic [8:0]  tens_x10;
        logic [3:0]  units;
        logic [8:0]  packed_val;
        prod       = 16'(d) * 16'd205;
        tens       = prod[15:11];
        tens_x10   = {tens, 3'b000} + {3'b000, tens, 1'b0};
        units      = 4'(9'(d) - tens_x10);
        packed_val = {tens, 4'b0000} + {5'b00000, units};
        return packed_val[7:0];
    endfunction

    // bcd to decimal, high nibble times ten plus low nibble
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi_x10;
        hi_x10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
        return hi_x10 + {4'b0000, b[3:0]};
    endfunction

endpackage

// ===== design/rtc_three_wire_serial_master_core.sv =====
// rtc_three_wire_serial_master_core: tick-driven three-wire serial master,
// lsb first, with optional bcd conversion; depends on rtc3w_pkg
//
// Usage:
//   Each input item is one half-period tick of the serial clock. It carries
//   kind (idle, start write, start read), command, value, convert and the
//   sampled io pin. Each accepted item gives exactly one result item with
//   the pin levels for that tick (chip_enable, serial_clock, io_out,
//   io_drive) and the status busy_res, done_res, read_value and refused.
//   A transaction takes 32 ticks; done_res marks the last, with read_value
//   holding the received byte on reads. A start while busy is refused.
//   Timing: the result item is registered, valid in the cycle after its
//   input item is accepted. Throughput: one item per cycle while the
//   receiver does not stall; the result register is the single stage.
//   The input side stalls only while a result waits and the receiver
//   stalls; a stalled result holds its value.
//   Reset: the block is idle, no result is pending and the first
//   transaction starts on the first start request.
module rtc_three_wire_serial_master_core
    import rtc3w_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] command,
    input  logic [7:0] value,
    input  logic       convert,
    input  logic       io_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       chip_enable,
    output logic       serial_clock,
    output logic       io_out,
    output logic       io_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_value,
    output logic       refused
);

    logic        active_reg, active_next;
    logic        reading_reg, reading_next;
    logic        convert_reg, convert_next;
    logic [5:0]  tick_reg, tick_next;
    logic [15:0] shift_reg, shift_next;
    logic [7:0]  recv_reg, recv_next;

    logic        out_valid_reg, out_valid_next;
    logic        ce_reg, ce_next;
    logic        sclk_reg, sclk_next;
    logic        io_reg, io_next;
    logic        drv_reg, drv_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  rv_reg, rv_next;
    logic        ref_reg, ref_next;

    logic        accept;
    logic        start;
    logic        cur_active;
    logic        cur_reading;
    logic        cur_convert;
    logic [4:0]  tick;
    logic [2:0]  slot;
    logic [7:0]  cur_recv;
    logic [7:0]  write_byte;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign start    = (kind == KIND_WRITE) || (kind == KIND_READ);
    assign out_valid_next = accept | (out_valid_reg & out_stall);
    assign write_byte = convert ? to_bcd(value) : value;

    always_comb
    begin
        cur_active   = active_reg;
        reading_next = reading_reg;
        convert_next = convert_reg;
        shift_next   = shift_reg;
        cur_recv     = recv_reg;
        tick         = tick_reg[4:0];
        ref_next     = 1'b0;
        if (active_reg)
        begin
            ref_next = start;
        end
        else if (start)
        begin
            cur_active   = 1'b1;
            reading_next = (kind == KIND_READ);
            convert_next = convert;
            tick         = 5'd0;
            cur_recv     = 8'd0;
            if (kind == KIND_READ)
                shift_next = {8'h00, command | READ_FLAG};
            else
                shift_next = {write_byte, command};
        end
        cur_reading = reading_next;
        cur_convert = convert_next;
        slot        = tick[3:1];

        ce_next     = 1'b0;
        sclk_next   = 1'b0;
        io_next     = 1'b0;
        drv_next    = 1'b0;
        done_next   = 1'b0;
        rv_next     = 8'd0;
        recv_next   = cur_recv;
        active_next = cur_active;
        tick_next   = {1'b0, tick};
        if (cur_active)
        begin
            ce_next = 1'b1;
            if (cur_reading && tick >= READ_START)
            begin
                sclk_next = ~tick[0];
                if (tick[0] && io_in)
                    recv_next = cur_recv | (8'h01 << slot);
            end
            else
            begin
                drv_next  = 1'b1;
                io_next   = shift_next[tick[4:1]];
                sclk_next = tick[0];
            end
            if (tick == LAST_TICK)
            begin
                done_next   = 1'b1;
                active_next = 1'b0;
                tick_next   = 6'd0;
                if (cur_reading)
                    rv_next = cur_convert ? from_bcd(recv_next) : recv_next;
            end
            else
            begin
                tick_next = {1'b0, tick} + 6'd1;
            end
        end
        busy_next = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            reading_reg   <= 1'b0;
            convert_reg   <= 1'b0;
            tick_reg      <= 6'd0;
            shift_reg     <= 16'd0;
            recv_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                active_reg  <= active_next;
                reading_reg <= reading_next;
                convert_reg <= convert_next;
                tick_reg    <= tick_next;
                shift_reg   <= shift_next;
                recv_reg    <= recv_next;
            end
        end
    end

    // result register, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ce_reg   <= ce_next;
            sclk_reg <= sclk_next;
            io_reg   <= io_next;
            drv_reg  <= drv_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            rv_reg   <= rv_next;
            ref_reg  <= ref_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chip_enable  = ce_reg;
    assign serial_clock = sclk_reg;
    assign io_out       = io_reg;
    assign io_drive     = drv_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign read_value   = rv_reg;
    assign refused      = ref_reg;

endmodule
